@@ hdl/axis_homing_and_feedforward_sequencer_macros.svh @@
// ----------------------------------------------------------------------------
// Lift-axis sequencer assertion macros
// Shared concurrent assertion forms, clocked on aclk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef AXIS_HOMING_AND_FEEDFORWARD_SEQUENCER_MACROS_SVH
`define AXIS_HOMING_AND_FEEDFORWARD_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define AHFS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AHFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ahfs_pkg.sv @@
// ----------------------------------------------------------------------------
// Lift-axis sequencer package
// Field widths, register indexes, item kinds and reset values.
// ----------------------------------------------------------------------------
package ahfs_pkg;

    localparam int POS_W      = 16;
    localparam int LIMIT_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TDATA_W    = 40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_HEIGHT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FF_ABOVE_STAGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FF_BELOW_STAGE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FF_SLOW_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOMING_DRIVE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOMING_TIMEOUT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TARGET      = 3'd6;

    // Item kinds carried in s_tuser
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    localparam logic [15:0]        HOMING_TIMEOUT_RST = 16'd100;
    localparam logic [LIMIT_W-1:0] MAX_TARGET_RST     = 15'd6963;   // 1.7 in Q4.12
    localparam logic [POS_W-1:0]   PREV_POSITION_RST  = 16'hF000;   // -1.0 in Q4.12
    localparam logic [15:0]        TIMER_MAX          = 16'hFFFF;

    typedef struct packed {
        logic                    slow_profile;
        logic signed [POS_W-1:0] target;
        logic                    moving_down;
        logic signed [POS_W-1:0] position;
        logic                    motor_disabled;
        logic                    limit_switch;
    } in_item_t;

    typedef struct packed {
        logic                    accepted;
        logic                    homing_timed_out;
        logic                    zero_sensor;
        logic signed [POS_W-1:0] feed_forward;
        logic                    use_slow;
        logic signed [POS_W-1:0] drive_value;
    } out_item_t;

endpackage

@@ hdl/axis_homing_and_feedforward_sequencer.sv @@
// ----------------------------------------------------------------------------
// Lift-axis homing and feed-forward sequencer
// Seeks the home switch with a fixed percent drive, then runs profiled
// position control with stage-dependent feed-forward.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transaction contents
//  s_axis    in         tuser: kind; tdata: tick fields or command fields
//  m_axis    out        tuser: profiled_mode; tdata: drive and status fields
//  cfg       in         write enable, register index, write data
//
//  One item per cycle sustained while m_tready holds high; each result is
//  registered in the result register as its item leaves the input register.
//  The input register and the result register form a two-entry pipeline;
//  a stalled m_tready holds both and then drops s_tready.
//  aresetn is synchronous, active low, and restores all sequencer state.
// ----------------------------------------------------------------------------
`include "axis_homing_and_feedforward_sequencer_macros.svh"

module axis_homing_and_feedforward_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] limit_switch, [1] motor_disabled, [17:2] position, [18] moving_down,
    // [34:19] target, [35] slow_profile, [39:36] zero
    input  logic [ahfs_pkg::TDATA_W-1:0]        s_tdata,
    // [0] kind
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] drive_value, [16] use_slow, [32:17] feed_forward, [33] zero_sensor,
    // [34] homing_timed_out, [35] accepted, [39:36] zero
    output logic [ahfs_pkg::TDATA_W-1:0]        m_tdata,
    // [0] profiled_mode
    output logic                                m_tuser,
    input  logic                                cfg_wr_en,
    input  logic [ahfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ahfs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int PW = ahfs_pkg::POS_W;
    localparam int LW = ahfs_pkg::LIMIT_W;

    // Configuration registers
    logic [LW-1:0]        stage_height_reg;
    logic signed [PW-1:0] ff_above_stage_reg;
    logic signed [PW-1:0] ff_below_stage_reg;
    logic signed [PW-1:0] ff_slow_mode_reg;
    logic signed [PW-1:0] homing_drive_reg;
    logic [15:0]          homing_timeout_reg;
    logic [LW-1:0]        max_target_reg;

    // Sequencer state
    logic                 homed_reg,         homed_next;
    logic                 switch_seen_reg,   switch_seen_next;
    logic [15:0]          down_timer_reg,    down_timer_next;
    logic signed [PW-1:0] prev_position_reg, prev_position_next;
    logic                 prev_disabled_reg, prev_disabled_next;
    logic signed [PW-1:0] ff_hold_reg,       ff_hold_next;
    logic signed [PW-1:0] goal_position_reg, goal_position_next;
    logic                 goal_slow_reg,     goal_slow_next;

    // Pipeline registers
    logic                 in_valid_reg;
    ahfs_pkg::in_item_t   in_item_reg;
    logic                 in_kind_reg;
    logic                 out_valid_reg;
    ahfs_pkg::out_item_t  out_item_reg,  out_item_next;
    logic                 out_mode_reg,  out_mode_next;

    logic                 advance;
    logic                 zero_pulse;
    logic signed [LW:0]   stage_s;
    logic signed [LW:0]   max_target_s;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_mode_reg;
    assign m_tdata  = {{(ahfs_pkg::TDATA_W - $bits(ahfs_pkg::out_item_t)){1'b0}},
                       out_item_reg};

    assign stage_s      = $signed({1'b0, stage_height_reg});
    assign max_target_s = $signed({1'b0, max_target_reg});

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_height_reg   <= '0;
            ff_above_stage_reg <= '0;
            ff_below_stage_reg <= '0;
            ff_slow_mode_reg   <= '0;
            homing_drive_reg   <= '0;
            homing_timeout_reg <= ahfs_pkg::HOMING_TIMEOUT_RST;
            max_target_reg     <= ahfs_pkg::MAX_TARGET_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ahfs_pkg::REG_STAGE_HEIGHT:   stage_height_reg   <= cfg_wdata[LW-1:0];
                ahfs_pkg::REG_FF_ABOVE_STAGE: ff_above_stage_reg <= $signed(cfg_wdata);
                ahfs_pkg::REG_FF_BELOW_STAGE: ff_below_stage_reg <= $signed(cfg_wdata);
                ahfs_pkg::REG_FF_SLOW_MODE:   ff_slow_mode_reg   <= $signed(cfg_wdata);
                ahfs_pkg::REG_HOMING_DRIVE:   homing_drive_reg   <= $signed(cfg_wdata);
                ahfs_pkg::REG_HOMING_TIMEOUT: homing_timeout_reg <= cfg_wdata;
                ahfs_pkg::REG_MAX_TARGET:     max_target_reg     <= cfg_wdata[LW-1:0];
                default: ;
            endcase
        end
    end

    // Per-item sequencing
    always_comb begin
        homed_next         = homed_reg;
        switch_seen_next   = switch_seen_reg;
        down_timer_next    = down_timer_reg;
        prev_position_next = prev_position_reg;
        prev_disabled_next = prev_disabled_reg;
        ff_hold_next       = ff_hold_reg;
        goal_position_next = goal_position_reg;
        goal_slow_next     = goal_slow_reg;
        out_item_next      = '0;
        out_mode_next      = 1'b0;
        zero_pulse         = 1'b0;

        if (in_kind_reg == ahfs_pkg::KIND_COMMAND) begin
            if (in_item_reg.target <= max_target_s) begin
                goal_position_next     = in_item_reg.target;
                goal_slow_next         = in_item_reg.slow_profile;
                out_item_next.accepted = 1'b1;
            end
        end else begin
            // Home switch: only a rising edge zeroes the sensor
            if (in_item_reg.limit_switch) begin
                if (!switch_seen_reg) begin
                    homed_next       = 1'b1;
                    switch_seen_next = 1'b1;
                    zero_pulse       = 1'b1;
                    ff_hold_next     = ff_below_stage_reg;
                end
            end else begin
                switch_seen_next = 1'b0;
            end

            if (homed_next) begin
                // Disable edge: hold the current position
                if (in_item_reg.motor_disabled && !prev_disabled_reg) begin
                    goal_position_next = in_item_reg.position;
                    goal_slow_next     = 1'b0;
                end
                if (!goal_slow_next) begin
                    if (in_item_reg.position >= stage_s &&
                        prev_position_reg <= stage_s) begin
                        ff_hold_next = ff_above_stage_reg;
                    end else if (in_item_reg.position <= stage_s &&
                                 prev_position_reg >= stage_s) begin
                        ff_hold_next = ff_below_stage_reg;
                    end
                end else begin
                    ff_hold_next = ff_slow_mode_reg;
                end
                out_mode_next              = 1'b1;
                out_item_next.drive_value  = goal_position_next;
                out_item_next.use_slow     = goal_slow_next;
            end else begin
                if (down_timer_reg < homing_timeout_reg) begin
                    out_item_next.drive_value = homing_drive_reg;
                end else begin
                    out_item_next.homing_timed_out = 1'b1;
                end
                if (in_item_reg.motor_disabled || in_item_reg.moving_down) begin
                    down_timer_next = '0;
                end else if (down_timer_reg != ahfs_pkg::TIMER_MAX) begin
                    down_timer_next = down_timer_reg + 16'd1;
                end
            end

            out_item_next.feed_forward = ff_hold_next;
            out_item_next.zero_sensor  = zero_pulse;
            prev_position_next         = in_item_reg.position;
            prev_disabled_next         = in_item_reg.motor_disabled;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= s_tdata[$bits(ahfs_pkg::in_item_t)-1:0];
            in_kind_reg <= s_tuser;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= out_item_next;
            out_mode_reg <= out_mode_next;
        end
    end

    // State commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            homed_reg         <= 1'b0;
            switch_seen_reg   <= 1'b0;
            down_timer_reg    <= '0;
            prev_position_reg <= $signed(ahfs_pkg::PREV_POSITION_RST);
            prev_disabled_reg <= 1'b1;
            ff_hold_reg       <= '0;
            goal_position_reg <= '0;
            goal_slow_reg     <= 1'b0;
        end else if (advance) begin
            homed_reg         <= homed_next;
            switch_seen_reg   <= switch_seen_next;
            down_timer_reg    <= down_timer_next;
            prev_position_reg <= prev_position_next;
            prev_disabled_reg <= prev_disabled_next;
            ff_hold_reg       <= ff_hold_next;
            goal_position_reg <= goal_position_next;
            goal_slow_reg     <= goal_slow_next;
        end
    end

    `AHFS_ASSERT_NEXT(a_homed_sticky, homed_reg, homed_reg,
        "homed state cleared without reset")
    `AHFS_ASSERT_IMPLY(a_zero_in_profiled, out_valid_reg && out_item_reg.zero_sensor,
        out_mode_reg, "sensor zero pulse outside profiled mode")
    `AHFS_ASSERT_IMPLY(a_timeout_drive, out_valid_reg && out_item_reg.homing_timed_out,
        !out_mode_reg && out_item_reg.drive_value == '0,
        "timed-out homing still drives")
    `AHFS_ASSERT_IMPLY(a_accept_clean, out_valid_reg && out_item_reg.accepted,
        !out_mode_reg && out_item_reg.feed_forward == '0 && !out_item_reg.zero_sensor,
        "accepted command carries tick fields")
    `AHFS_ASSERT_IMPLY(a_full_stall, in_valid_reg && out_valid_reg && !m_tready,
        !s_tready, "input taken while pipeline is full and stalled")

endmodule
